@@ rtl/serial_frame_deframer_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame deframer queue
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_QUEUE_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define SFDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SFDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sfdq_pkg.sv @@
// ----------------------------------------------------------------------------
// sfdq_pkg
// Types and fixed constants shared by the frame deframer queue modules.
// ----------------------------------------------------------------------------
package sfdq_pkg;

	// Configuration port geometry and register indexes.
	localparam int APB_AW = 4;
	localparam logic [1:0] REG_HEAD  = 2'd0;
	localparam logic [1:0] REG_TAIL0 = 2'd1;
	localparam logic [1:0] REG_TAIL1 = 2'd2;
	localparam logic [1:0] REG_TAIL2 = 2'd3;

	// Register reset values.
	localparam logic [7:0] HEAD_RST  = 8'hEE;
	localparam logic [7:0] TAIL0_RST = 8'hFF;
	localparam logic [7:0] TAIL1_RST = 8'hFC;
	localparam logic [7:0] TAIL2_RST = 8'hFF;

	// Queue depths and fixed field widths.
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);
	localparam int LEN_OUT_W  = 6;

	// Command classes produced by the front end.
	typedef enum logic [1:0] {
		OP_DATA,
		OP_HEAD,
		OP_POP
	} op_e;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_EMPTY     = 2'd1,
		KIND_NOT_READY = 2'd2
	} kind_e;

	// Slot assembly phases.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TAIL0,
		PH_TAIL1,
		PH_TAIL2,
		PH_DONE
	} phase_e;

	// Back-end sequencer states.
	typedef enum logic {
		BK_IDLE,
		BK_STREAM
	} bk_state_e;

	typedef struct packed {
		op_e        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] third;
	} tail_cfg_t;

	typedef struct packed {
		kind_e                  kind;
		logic [7:0]             payload;
		logic                   last;
		logic [LEN_OUT_W-1:0]   frame_length;
		logic                   overwrite;
		logic                   overflow;
		logic [31:0]            not_ready;
		logic [31:0]            delivered;
	} res_t;

endpackage

@@ rtl/sfdq_ram.sv @@
// ----------------------------------------------------------------------------
// sfdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/sfdq_front.sv @@
// ----------------------------------------------------------------------------
// sfdq_front
// Accepts input beats, classifies them and holds them in a short command queue.
// ----------------------------------------------------------------------------
module sfdq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              mode,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        head_byte,
	output logic              cmd_valid,
	output sfdq_pkg::cmd_t    cmd,
	input  logic              cmd_take
);

	localparam int PW = $clog2(sfdq_pkg::CMDQ_DEPTH);
	localparam int CW = $clog2(sfdq_pkg::CMDQ_DEPTH + 1);

	sfdq_pkg::cmd_t ent_q [sfdq_pkg::CMDQ_DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	sfdq_pkg::cmd_t in_cmd;
	logic           acc;

	// Classify the incoming beat: pop request, head byte or other byte.
	always_comb begin
		in_cmd.data = rx_byte;
		if (mode) begin
			in_cmd.op = sfdq_pkg::OP_POP;
		end else if (rx_byte == head_byte) begin
			in_cmd.op = sfdq_pkg::OP_HEAD;
		end else begin
			in_cmd.op = sfdq_pkg::OP_DATA;
		end
	end

	assign full      = (count_q == CW'(sfdq_pkg::CMDQ_DEPTH));
	assign acc       = push && !full;
	assign cmd_valid = (count_q != '0);
	assign cmd       = ent_q[rptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wptr_q] <= in_cmd;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (acc) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (cmd_take) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (acc && !cmd_take) begin
				count_q <= count_q + CW'(1);
			end else if (!acc && cmd_take) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/sfdq_back.sv @@
// ----------------------------------------------------------------------------
// sfdq_back
// Executes commands: assembles frames into slots and streams popped frames.
// ----------------------------------------------------------------------------
`include "serial_frame_deframer_queue_defines.svh"

module sfdq_back #(
	parameter int FRAME_BYTES = 32,
	parameter int SLOT_COUNT  = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	input  sfdq_pkg::cmd_t                 cmd,
	output logic                           cmd_take,
	input  sfdq_pkg::tail_cfg_t            tails,
	input  logic [sfdq_pkg::RESQ_CW-1:0]   rq_count,
	output logic                           rq_push,
	output sfdq_pkg::res_t                 rq_data
);

	localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int LW    = $clog2(FRAME_BYTES + 1);
	localparam int DEPTH = SLOT_COUNT * FRAME_BYTES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Slot state.
	sfdq_pkg::phase_e phase_q [SLOT_COUNT];
	logic [LW-1:0]    len_q   [SLOT_COUNT];
	logic [SW-1:0]    wr_slot_q, wr_slot_d;
	logic [SW-1:0]    rd_slot_q, rd_slot_d;
	logic             ovw_q, ovw_d;
	logic             ovf_q, ovf_d;
	logic [31:0]      nrc_q, nrc_d;
	logic [31:0]      dlc_q, dlc_d;

	// Sequencer state.
	sfdq_pkg::bk_state_e state_q, state_d;
	logic [SW-1:0]       str_slot_q, str_slot_d;
	logic [LW-1:0]       str_idx_q, str_idx_d;
	logic [LW-1:0]       str_len_q, str_len_d;

	// Array access at the current slot.
	logic [SW-1:0]    cur_slot;
	sfdq_pkg::phase_e cur_ph;
	logic [LW-1:0]    cur_len;
	logic             ph_we;
	sfdq_pkg::phase_e ph_wd;
	logic             len_we;
	logic [LW-1:0]    len_wd;

	// Frame store ports.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// Result issue.
	logic            room;
	logic            issue;
	sfdq_pkg::kind_e kind_d;
	logic            last_d;
	logic [LW-1:0]   rlen_d;
	logic            from_ram_d;

	// Result stage aligned with the RAM read data.
	logic            valid_s1;
	sfdq_pkg::kind_e kind_s1;
	logic            last_s1;
	logic [LW-1:0]   len_s1;
	logic            from_ram_s1;
	logic            ovw_s1;
	logic            ovf_s1;
	logic [31:0]     nrc_s1;
	logic [31:0]     dlc_s1;

	// Next slot round the ring.
	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		logic [SW-1:0] n;
		if (s == SW'(SLOT_COUNT - 1)) begin
			n = '0;
		end else begin
			n = s + SW'(1);
		end
		return n;
	endfunction

	// Byte address of an entry within a slot.
	function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
		input logic [LW-1:0] idx);
		logic [AW:0] a;
		a = (AW + 1)'(s) * (AW + 1)'(FRAME_BYTES) + (AW + 1)'(idx);
		return a[AW-1:0];
	endfunction

	assign cur_slot = (cmd.op == sfdq_pkg::OP_POP) ? rd_slot_q : wr_slot_q;
	assign cur_ph   = phase_q[cur_slot];
	assign cur_len  = len_q[cur_slot];
	assign room     = ({1'b0, rq_count} + {{sfdq_pkg::RESQ_CW{1'b0}}, valid_s1})
		< (sfdq_pkg::RESQ_CW + 1)'(sfdq_pkg::RESQ_DEPTH);
	assign ram_waddr = slot_addr(wr_slot_q, cur_len);

	// Command execution and streaming sequencer.
	always_comb begin
		state_d    = state_q;
		str_slot_d = str_slot_q;
		str_idx_d  = str_idx_q;
		str_len_d  = str_len_q;
		wr_slot_d  = wr_slot_q;
		rd_slot_d  = rd_slot_q;
		ovw_d      = ovw_q;
		ovf_d      = ovf_q;
		nrc_d      = nrc_q;
		dlc_d      = dlc_q;
		cmd_take   = 1'b0;
		ph_we      = 1'b0;
		ph_wd      = sfdq_pkg::PH_IDLE;
		len_we     = 1'b0;
		len_wd     = '0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = slot_addr(str_slot_q, str_idx_q);
		issue      = 1'b0;
		kind_d     = sfdq_pkg::KIND_PAYLOAD;
		last_d     = 1'b0;
		rlen_d     = '0;
		from_ram_d = 1'b0;
		unique case (state_q)
			sfdq_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						sfdq_pkg::OP_HEAD: begin
							// A head restarts the write slot.
							cmd_take = 1'b1;
							if (cur_ph == sfdq_pkg::PH_DONE) begin
								ovw_d = 1'b1;
							end
							ph_we  = 1'b1;
							ph_wd  = sfdq_pkg::PH_TAIL0;
							len_we = 1'b1;
							len_wd = '0;
						end
						sfdq_pkg::OP_DATA: begin
							cmd_take = 1'b1;
							if (cur_ph == sfdq_pkg::PH_TAIL0) begin
								if (cmd.data == tails.first) begin
									ph_we = 1'b1;
									ph_wd = sfdq_pkg::PH_TAIL1;
								end else if (cur_len < LW'(FRAME_BYTES)) begin
									ram_we = 1'b1;
									len_we = 1'b1;
									len_wd = cur_len + LW'(1);
								end else begin
									ovf_d = 1'b1;
								end
							end else if (cur_ph == sfdq_pkg::PH_TAIL1 &&
								cmd.data == tails.second) begin
								ph_we = 1'b1;
								ph_wd = sfdq_pkg::PH_TAIL2;
							end else if (cur_ph == sfdq_pkg::PH_TAIL2 &&
								cmd.data == tails.third) begin
								ph_we     = 1'b1;
								ph_wd     = sfdq_pkg::PH_DONE;
								wr_slot_d = next_slot(wr_slot_q);
							end
						end
						sfdq_pkg::OP_POP: begin
							if (room) begin
								cmd_take = 1'b1;
								issue    = 1'b1;
								if (cur_ph != sfdq_pkg::PH_DONE) begin
									nrc_d  = nrc_q + 32'd1;
									kind_d = sfdq_pkg::KIND_NOT_READY;
									last_d = 1'b1;
								end else begin
									ph_we     = 1'b1;
									ph_wd     = sfdq_pkg::PH_IDLE;
									dlc_d     = dlc_q + 32'd1;
									rd_slot_d = next_slot(rd_slot_q);
									if (cur_len == '0) begin
										kind_d = sfdq_pkg::KIND_EMPTY;
										last_d = 1'b1;
									end else begin
										// Issue the first payload byte at once.
										ram_re     = 1'b1;
										ram_raddr  = slot_addr(cur_slot, '0);
										from_ram_d = 1'b1;
										rlen_d     = cur_len;
										last_d     = (cur_len == LW'(1));
										if (cur_len != LW'(1)) begin
											state_d    = sfdq_pkg::BK_STREAM;
											str_slot_d = cur_slot;
											str_idx_d  = LW'(1);
											str_len_d  = cur_len;
										end
									end
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			sfdq_pkg::BK_STREAM: begin
				// One payload byte per cycle while the result queue has room.
				if (room) begin
					issue      = 1'b1;
					ram_re     = 1'b1;
					from_ram_d = 1'b1;
					rlen_d     = str_len_q;
					last_d     = ((str_idx_q + LW'(1)) == str_len_q);
					str_idx_d  = str_idx_q + LW'(1);
					if (last_d) begin
						state_d = sfdq_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = sfdq_pkg::BK_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				phase_q[i] <= sfdq_pkg::PH_IDLE;
				len_q[i]   <= '0;
			end
			wr_slot_q  <= '0;
			rd_slot_q  <= '0;
			ovw_q      <= 1'b0;
			ovf_q      <= 1'b0;
			nrc_q      <= '0;
			dlc_q      <= '0;
			state_q    <= sfdq_pkg::BK_IDLE;
			str_slot_q <= '0;
			str_idx_q  <= '0;
			str_len_q  <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (ph_we) begin
				phase_q[cur_slot] <= ph_wd;
			end
			if (len_we) begin
				len_q[cur_slot] <= len_wd;
			end
			wr_slot_q  <= wr_slot_d;
			rd_slot_q  <= rd_slot_d;
			ovw_q      <= ovw_d;
			ovf_q      <= ovf_d;
			nrc_q      <= nrc_d;
			dlc_q      <= dlc_d;
			state_q    <= state_d;
			str_slot_q <= str_slot_d;
			str_idx_q  <= str_idx_d;
			str_len_q  <= str_len_d;
			valid_s1   <= issue;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1     <= kind_d;
			last_s1     <= last_d;
			len_s1      <= rlen_d;
			from_ram_s1 <= from_ram_d;
			ovw_s1      <= ovw_d;
			ovf_s1      <= ovf_d;
			nrc_s1      <= nrc_d;
			dlc_s1      <= dlc_d;
		end
	end

	sfdq_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Assemble the result beat.
	always_comb begin
		rq_data.kind         = kind_s1;
		rq_data.payload      = from_ram_s1 ? ram_rdata : 8'h00;
		rq_data.last         = last_s1;
		rq_data.frame_length = sfdq_pkg::LEN_OUT_W'(len_s1);
		rq_data.overwrite    = ovw_s1;
		rq_data.overflow     = ovf_s1;
		rq_data.not_ready    = nrc_s1;
		rq_data.delivered    = dlc_s1;
	end
	assign rq_push = valid_s1;

	// A result beat always finds a free entry in the result queue.
	`SFDQ_ASSERT_IMPL(a_push_room, valid_s1, rq_count < sfdq_pkg::RESQ_CW'(sfdq_pkg::RESQ_DEPTH), "result pushed into a full queue")
	// The stream index never runs past the frame length.
	`SFDQ_ASSERT_IMPL(a_idx_range, state_q == sfdq_pkg::BK_STREAM, str_idx_q < str_len_q, "stream index beyond frame length")
	// Empty and not-ready results are single beats.
	`SFDQ_ASSERT_IMPL(a_single_beat, valid_s1 && kind_s1 != sfdq_pkg::KIND_PAYLOAD, last_s1 && !from_ram_s1, "status result not marked last")
	// A final payload read returns the sequencer to idle.
	`SFDQ_ASSERT_NEXT(a_last_idle, issue && last_d, state_q == sfdq_pkg::BK_IDLE, "sequencer did not return to idle")

endmodule

@@ rtl/sfdq_resq.sv @@
// ----------------------------------------------------------------------------
// sfdq_resq
// Result queue presenting finished result beats to the consumer.
// ----------------------------------------------------------------------------
module sfdq_resq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_push,
	input  sfdq_pkg::res_t                in_data,
	output logic [sfdq_pkg::RESQ_CW-1:0]  count,
	output logic                          empty,
	input  logic                          pop,
	output sfdq_pkg::res_t                head
);

	localparam int PW = $clog2(sfdq_pkg::RESQ_DEPTH);
	localparam int CW = sfdq_pkg::RESQ_CW;

	sfdq_pkg::res_t ent_q [sfdq_pkg::RESQ_DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           deq;

	assign empty = (count_q == '0);
	assign deq   = pop && !empty;
	assign count = count_q;
	assign head  = ent_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (in_push) begin
			ent_q[wptr_q] <= in_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (in_push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (deq) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (in_push && !deq) begin
				count_q <= count_q + CW'(1);
			end else if (!in_push && deq) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/serial_frame_deframer_queue.sv @@
// ----------------------------------------------------------------------------
// serial_frame_deframer_queue
// Deframes head/payload/tail byte streams into a ring of slots and pops frames.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Beat contents
//  input     push / full            mode, rx_byte
//  result    empty / pop            kind, payload_byte, last, frame_length,
//                                   overwrite_warning, overflow_warning,
//                                   not_ready_count, delivered_count
//  config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
//  The back-end sequencer takes a received byte only while it is not streaming.
//  A pop yields one result beat per cycle while the result queue has room
//  (payload length, at least one); the frame store's single read port sets this rate.
//  A result is registered in the result stage and then in the result queue.
//  Reset is immediate; the frame store needs no clearing pass.
//  Either side may stall; the command and result queues decouple them.
// ----------------------------------------------------------------------------
module serial_frame_deframer_queue #(
	parameter int FRAME_BYTES = 32,
	parameter int SLOT_COUNT  = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input queue side
	input  logic                          push,
	output logic                          full,
	input  logic                          mode,
	input  logic [7:0]                    rx_byte,
	// Result queue side
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    kind,
	output logic [7:0]                    payload_byte,
	output logic                          last,
	output logic [sfdq_pkg::LEN_OUT_W-1:0] frame_length,
	output logic                          overwrite_warning,
	output logic                          overflow_warning,
	output logic [31:0]                   not_ready_count,
	output logic [31:0]                   delivered_count,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfdq_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [7:0]                   head_q;
	logic [7:0]                   tail0_q;
	logic [7:0]                   tail1_q;
	logic [7:0]                   tail2_q;
	logic                         cfg_wr;
	logic                         cmd_valid;
	sfdq_pkg::cmd_t               cmd;
	logic                         cmd_take;
	sfdq_pkg::tail_cfg_t          tails;
	logic [sfdq_pkg::RESQ_CW-1:0] rq_count;
	logic                         rq_push;
	sfdq_pkg::res_t               rq_data;
	sfdq_pkg::res_t               rq_head;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= sfdq_pkg::HEAD_RST;
			tail0_q <= sfdq_pkg::TAIL0_RST;
			tail1_q <= sfdq_pkg::TAIL1_RST;
			tail2_q <= sfdq_pkg::TAIL2_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				sfdq_pkg::REG_HEAD:  head_q  <= pwdata[7:0];
				sfdq_pkg::REG_TAIL0: tail0_q <= pwdata[7:0];
				sfdq_pkg::REG_TAIL1: tail1_q <= pwdata[7:0];
				sfdq_pkg::REG_TAIL2: tail2_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			sfdq_pkg::REG_HEAD:  prdata = {24'h0, head_q};
			sfdq_pkg::REG_TAIL0: prdata = {24'h0, tail0_q};
			sfdq_pkg::REG_TAIL1: prdata = {24'h0, tail1_q};
			sfdq_pkg::REG_TAIL2: prdata = {24'h0, tail2_q};
			default:             prdata = 32'h0;
		endcase
	end

	assign tails.first  = tail0_q;
	assign tails.second = tail1_q;
	assign tails.third  = tail2_q;

	sfdq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.rx_byte   (rx_byte),
		.head_byte (head_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	sfdq_back #(
		.FRAME_BYTES (FRAME_BYTES),
		.SLOT_COUNT  (SLOT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.tails     (tails),
		.rq_count  (rq_count),
		.rq_push   (rq_push),
		.rq_data   (rq_data)
	);

	sfdq_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (rq_push),
		.in_data (rq_data),
		.count   (rq_count),
		.empty   (empty),
		.pop     (pop),
		.head    (rq_head)
	);

	// Unpack the oldest result beat onto the ports.
	assign kind              = rq_head.kind;
	assign payload_byte      = rq_head.payload;
	assign last              = rq_head.last;
	assign frame_length      = rq_head.frame_length;
	assign overwrite_warning = rq_head.overwrite;
	assign overflow_warning  = rq_head.overflow;
	assign not_ready_count   = rq_head.not_ready;
	assign delivered_count   = rq_head.delivered;

endmodule

@@ tb/sv/tb_serial_frame_deframer_queue.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the serial frame deframer queue
// Feeds received bytes and pop requests through the input queue, predicts
// every result beat with a behavioural copy of the slot ring, and checks each
// popped beat field by field. Both sides stall at random, the frame markers
// are reprogrammed between phases, and the ring is driven into overwrite and
// payload overflow.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_queue;

	localparam int FRAME_BYTES    = 32;
	localparam int SLOT_COUNT     = 4;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	// One item for the input queue: a received byte or a pop request.
	typedef struct {
		logic       is_pop;
		logic [7:0] data;
	} rx_item_t;

	// One predicted result beat.
	typedef struct {
		sfdq_pkg::kind_e kind;
		logic [7:0]      data;
		logic            last;
		logic [5:0]      length;
		logic            ow;
		logic            of;
		logic [31:0]     nr;
		logic [31:0]     dl;
	} frame_beat_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        push    = 1'b0;
	logic        mode    = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        pop     = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [sfdq_pkg::APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata  = 32'h0;

	logic        full;
	logic        empty;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic        last;
	logic [sfdq_pkg::LEN_OUT_W-1:0] frame_length;
	logic        overwrite_warning;
	logic        overflow_warning;
	logic [31:0] not_ready_count;
	logic [31:0] delivered_count;
	logic [31:0] prdata;
	logic        pready;

	// Frame markers as currently programmed.
	logic [7:0] cfg_head;
	logic [7:0] cfg_tail0;
	logic [7:0] cfg_tail1;
	logic [7:0] cfg_tail2;

	// Predicted slot ring.
	sfdq_pkg::phase_e slot_st [SLOT_COUNT];
	int          slot_len [SLOT_COUNT];
	logic [7:0]  slot_bytes [SLOT_COUNT][FRAME_BYTES];
	int          wr_slot;
	int          rd_slot;
	logic        ow_flag;
	logic        of_flag;
	logic [31:0] not_ready_cnt;
	logic [31:0] delivered_cnt;

	rx_item_t    pending [$];
	frame_beat_t beats_due [$];
	rx_item_t    head_item;

	int          queued_total = 0;
	int          sent_total = 0;
	int          beats_checked = 0;
	int          cfg_writes = 0;
	int          errors = 0;
	int          quiet_cycles = 0;
	int unsigned send_wait = 0;
	int unsigned take_wait = 0;
	bit          send_calm = 1'b0;
	bit          take_calm = 1'b0;
	bit          holding;

	serial_frame_deframer_queue #(
		.FRAME_BYTES(FRAME_BYTES),
		.SLOT_COUNT (SLOT_COUNT)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.mode             (mode),
		.rx_byte          (rx_byte),
		.empty            (empty),
		.pop              (pop),
		.kind             (kind),
		.payload_byte     (payload_byte),
		.last             (last),
		.frame_length     (frame_length),
		.overwrite_warning(overwrite_warning),
		.overflow_warning (overflow_warning),
		.not_ready_count  (not_ready_count),
		.delivered_count  (delivered_count),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Per-beat wait; runs of zero waits switch on and off at random.
	function automatic int unsigned next_gap(inout bit calm_run);
		if ($urandom_range(0, 15) == 0)
			calm_run = !calm_run;
		return calm_run ? 0 : $urandom_range(0, 17);
	endfunction

	// Record one expected result beat with the flags and counters as they now stand.
	task automatic push_beat(input sfdq_pkg::kind_e k, input logic [7:0] d,
		input logic lst, input int n);
		frame_beat_t w;
		w.kind   = k;
		w.data   = d;
		w.last   = lst;
		w.length = 6'(n);
		w.ow     = ow_flag;
		w.of     = of_flag;
		w.nr     = not_ready_cnt;
		w.dl     = delivered_cnt;
		beats_due.push_back(w);
	endtask

	// Advance the predicted slot ring by one accepted input beat.
	task automatic absorb_item(input logic is_pop, input logic [7:0] b);
		int s;
		int n;
		int i;
		if (is_pop) begin
			s = rd_slot;
			if (slot_st[s] != sfdq_pkg::PH_DONE) begin
				not_ready_cnt++;
				push_beat(sfdq_pkg::KIND_NOT_READY, 8'h00, 1'b1, 0);
			end else begin
				n = slot_len[s];
				slot_st[s] = sfdq_pkg::PH_IDLE;
				delivered_cnt++;
				rd_slot = (s + 1) % SLOT_COUNT;
				if (n == 0)
					push_beat(sfdq_pkg::KIND_EMPTY, 8'h00, 1'b1, 0);
				else
					for (i = 0; i < n; i++)
						push_beat(sfdq_pkg::KIND_PAYLOAD, slot_bytes[s][i], i == n - 1, n);
			end
		end else begin
			s = wr_slot;
			// The head test wins over every tail test.
			if (b == cfg_head) begin
				if (slot_st[s] == sfdq_pkg::PH_DONE)
					ow_flag = 1'b1;
				slot_st[s] = sfdq_pkg::PH_TAIL0;
				slot_len[s] = 0;
			end else if (slot_st[s] == sfdq_pkg::PH_TAIL0) begin
				if (b == cfg_tail0) begin
					slot_st[s] = sfdq_pkg::PH_TAIL1;
				end else if (slot_len[s] < FRAME_BYTES) begin
					slot_bytes[s][slot_len[s]] = b;
					slot_len[s]++;
				end else begin
					of_flag = 1'b1;
				end
			end else if (slot_st[s] == sfdq_pkg::PH_TAIL1 && b == cfg_tail1) begin
				slot_st[s] = sfdq_pkg::PH_TAIL2;
			end else if (slot_st[s] == sfdq_pkg::PH_TAIL2 && b == cfg_tail2) begin
				slot_st[s] = sfdq_pkg::PH_DONE;
				wr_slot = (s + 1) % SLOT_COUNT;
			end
		end
	endtask

	task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t MISMATCH %s: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare the beat on the result ports with the oldest expectation.
	task automatic check_beat();
		frame_beat_t w;
		if (beats_due.size() == 0) begin
			$display("%0t MISMATCH unexpected beat: expected none, actual kind %0d byte %0h",
				$time, kind, payload_byte);
			errors++;
		end else begin
			w = beats_due.pop_front();
			cmp("kind", 32'(w.kind), 32'(kind));
			cmp("payload_byte", 32'(w.data), 32'(payload_byte));
			cmp("last", 32'(w.last), 32'(last));
			cmp("frame_length", 32'(w.length), 32'(frame_length));
			cmp("overwrite_warning", 32'(w.ow), 32'(overwrite_warning));
			cmp("overflow_warning", 32'(w.of), 32'(overflow_warning));
			cmp("not_ready_count", w.nr, not_ready_count);
			cmp("delivered_count", w.dl, delivered_count);
		end
		beats_checked++;
	endtask

	// Input driver: one item per beat, with a drawn pause after each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push    <= 1'b0;
			mode    <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			holding = push;
			if (push && !full) begin
				absorb_item(mode, rx_byte);
				sent_total++;
				send_wait = next_gap(send_calm);
				holding = 1'b0;
			end
			if (!holding) begin
				if (send_wait != 0) begin
					send_wait--;
					push <= 1'b0;
				end else if (pending.size() != 0) begin
					head_item = pending.pop_front();
					push    <= 1'b1;
					mode    <= head_item.is_pop;
					rx_byte <= head_item.data;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each popped beat, then stalls for a drawn time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				check_beat();
				take_wait = next_gap(take_calm);
			end
			if (take_wait != 0) begin
				take_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any beat on either queue or the register port.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (psel && penable)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
				$display("tb_serial_frame_deframer_queue failed");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	task automatic reset_model();
		int s;
		cfg_head  = sfdq_pkg::HEAD_RST;
		cfg_tail0 = sfdq_pkg::TAIL0_RST;
		cfg_tail1 = sfdq_pkg::TAIL1_RST;
		cfg_tail2 = sfdq_pkg::TAIL2_RST;
		for (s = 0; s < SLOT_COUNT; s++) begin
			slot_st[s]  = sfdq_pkg::PH_IDLE;
			slot_len[s] = 0;
		end
		wr_slot = 0;
		rd_slot = 0;
		ow_flag = 1'b0;
		of_flag = 1'b0;
		not_ready_cnt = 32'h0;
		delivered_cnt = 32'h0;
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= sfdq_pkg::APB_AW'({idx, 2'b00});
		pwdata  <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// The register takes its value at this edge.
		case (idx)
			sfdq_pkg::REG_HEAD:  cfg_head  = val;
			sfdq_pkg::REG_TAIL0: cfg_tail0 = val;
			sfdq_pkg::REG_TAIL1: cfg_tail1 = val;
			sfdq_pkg::REG_TAIL2: cfg_tail2 = val;
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_writes++;
	endtask

	task automatic set_markers(input logic [7:0] h, input logic [7:0] t0,
		input logic [7:0] t1, input logic [7:0] t2);
		cfg_write(sfdq_pkg::REG_HEAD, h);
		cfg_write(sfdq_pkg::REG_TAIL0, t0);
		cfg_write(sfdq_pkg::REG_TAIL1, t1);
		cfg_write(sfdq_pkg::REG_TAIL2, t2);
	endtask

	// Hold the sender until every expected beat has come and the block has settled.
	task automatic wait_idle();
		while (sent_total != queued_total || beats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_byte(input logic [7:0] b);
		rx_item_t it;
		it.is_pop = 1'b0;
		it.data   = b;
		pending.push_back(it);
		queued_total++;
	endtask

	task automatic queue_pop();
		rx_item_t it;
		it.is_pop = 1'b1;
		it.data   = 8'($urandom);
		pending.push_back(it);
		queued_total++;
	endtask

	// A payload byte that neither restarts nor ends the frame.
	function automatic logic [7:0] payload_pick();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == cfg_head || b == cfg_tail0);
		return b;
	endfunction

	// A byte that should be ignored while waiting for the given tail byte.
	function automatic logic [7:0] stray_pick(input logic [7:0] awaited);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == cfg_head || b == awaited);
		return b;
	endfunction

	// A well-formed frame, optionally with stray bytes between the tail bytes.
	task automatic queue_frame(input int len, input bit flawed);
		int i;
		queue_byte(cfg_head);
		for (i = 0; i < len; i++)
			queue_byte(payload_pick());
		queue_byte(cfg_tail0);
		if (flawed && $urandom_range(0, 1) == 1)
			queue_byte(stray_pick(cfg_tail1));
		queue_byte(cfg_tail1);
		if (flawed && $urandom_range(0, 1) == 1)
			queue_byte(stray_pick(cfg_tail2));
		queue_byte(cfg_tail2);
	endtask

	// Mostly whole frames and pops, with noise bytes and cut-off frames.
	task automatic mixed_traffic(input int count);
		int start;
		int pick;
		int len;
		start = queued_total;
		while (queued_total - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				if ($urandom_range(0, 19) == 0)
					len = $urandom_range(28, FRAME_BYTES + 2);
				else
					len = $urandom_range(0, 6);
				queue_frame(len, $urandom_range(0, 3) == 0);
			end else if (pick < 78) begin
				queue_pop();
			end else if (pick < 90) begin
				queue_byte(8'($urandom));
			end else begin
				queue_byte(cfg_head);
				repeat ($urandom_range(0, 3)) queue_byte(payload_pick());
				if ($urandom_range(0, 1) == 1)
					queue_byte(cfg_tail0);
			end
		end
	endtask

	// Fill every slot without reading, then restart a complete slot, then read all.
	task automatic fill_ring();
		repeat (SLOT_COUNT + 1) queue_frame($urandom_range(0, 2), 1'b0);
		repeat (SLOT_COUNT + 1) queue_pop();
	endtask

	// Stimulus sequence.
	initial begin
		logic [7:0] h;
		logic [7:0] t0;
		logic [7:0] t1;
		logic [7:0] t2;

		reset_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: pop with nothing ready, ignored byte while idle, empty frame.
		queue_pop();
		queue_byte(8'h12);
		queue_frame(0, 1'b0);
		queue_pop();
		// Extreme payload values with stray second and third tail bytes.
		queue_byte(cfg_head);
		queue_byte(8'h00);
		queue_byte(8'hFE);
		queue_byte(8'h01);
		queue_byte(cfg_tail0);
		queue_byte(8'h13);
		queue_byte(cfg_tail1);
		queue_byte(8'h00);
		queue_byte(cfg_tail2);
		// A second head in mid-payload restarts the slot.
		queue_byte(cfg_head);
		queue_byte(8'h55);
		queue_byte(cfg_head);
		queue_byte(8'hAA);
		queue_byte(cfg_tail0);
		queue_byte(cfg_tail1);
		queue_byte(cfg_tail2);
		queue_pop();
		queue_pop();
		wait_idle();

		// Random traffic on reset markers, then overwrite of an unread frame.
		mixed_traffic(4);
		fill_ring();
		wait_idle();

		// Low head, high first tail; one frame past slot capacity.
		set_markers(8'h00, 8'hFF, 8'h80, 8'h7F);
		queue_frame(FRAME_BYTES + 1, 1'b0);
		queue_pop();
		mixed_traffic(4);
		wait_idle();

		// High head, all tails at zero.
		set_markers(8'hFF, 8'h00, 8'h00, 8'h00);
		mixed_traffic(4);
		wait_idle();

		// Head equal to first tail: the head always wins, so no frame completes.
		set_markers(8'h5A, 8'h5A, 8'hA5, 8'h3C);
		mixed_traffic(3);
		wait_idle();

		// Random markers, each tail distinct from the head, then flush every slot.
		h = 8'($urandom);
		do t0 = 8'($urandom); while (t0 == h);
		do t1 = 8'($urandom); while (t1 == h);
		do t2 = 8'($urandom); while (t2 == h);
		set_markers(h, t0, t1, t2);
		mixed_traffic(4);
		repeat (SLOT_COUNT) queue_pop();
		wait_idle();

		$display("Run covered %0d input beats and %0d result beats over %0d register writes.",
			sent_total, beats_checked, cfg_writes);
		$display("Frames delivered %0d, pops with no frame %0d, overwrite %0b, overflow %0b.",
			delivered_cnt, not_ready_cnt, ow_flag, of_flag);
		if (errors == 0)
			$display("tb_serial_frame_deframer_queue passed");
		else
			$display("tb_serial_frame_deframer_queue failed");
		$finish;
	end

endmodule
